// File: design/prld_pkg.sv
// Package for the pixel run-length decoder.
// Holds field widths, header type codes, result and error codes and the decoder phase type.
// No dependencies; every other design file imports it.
package prld_pkg;

  localparam int WORD_BITS    = 32;
  localparam int COUNT_BITS   = 16;
  localparam int LINE_BITS    = 12;
  localparam int DIM_BITS     = 13;
  localparam int LIMIT_BITS   = 25;
  localparam int POINTER_BITS = 25;
  localparam int CONSUMED_BITS = 26;
  localparam int PIXELS_BITS  = 2 * DIM_BITS;
  localparam int ADDR_PORT_BITS = 24;
  localparam int CFG_INDEX_BITS = 2;

  // Address bits kept in the reported pixel address.
  localparam int ADDRESS_BITS = 24;

  // Header type codes. End is tested first, then literal, literal at line,
  // run and run at line.
  localparam logic [3:0] TYPE_END             = 4'd0;
  localparam logic [3:0] TYPE_LITERAL         = 4'd1;
  localparam logic [3:0] TYPE_LITERAL_AT_LINE = 4'd2;
  localparam logic [3:0] TYPE_RUN             = 4'd3;
  localparam logic [3:0] TYPE_RUN_AT_LINE     = 4'd4;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_PIXEL = 3'd1;
  localparam logic [2:0] KIND_RUN   = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_DEST_OVER  = 2'd1;
  localparam logic [1:0] ERR_SRC_OVER   = 2'd2;
  localparam logic [1:0] ERR_BAD_TYPE   = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CODE_LIMIT   = 2'd2;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = '0;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_RUN
  } phase_t;

endpackage

// File: design/prld_channels.sv
// Channel interfaces of the pixel run-length decoder: code words in, results out, and
// the configuration write channel. Depends on prld_pkg for field widths.
interface prld_code_if import prld_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] code_word;
  logic                 stream_start;

  modport source (output valid, output code_word, output stream_start, input ready);
  modport sink   (input valid, input code_word, input stream_start, output ready);
endinterface

interface prld_result_if import prld_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                result_kind;
  logic [ADDR_PORT_BITS-1:0] pixel_address;
  logic [COUNT_BITS-1:0]     run_length;
  logic [WORD_BITS-1:0]      pixel_data;
  logic [1:0]                error_code;

  modport source (output valid, output result_kind, output pixel_address, output run_length,
                  output pixel_data, output error_code, input ready);
  modport sink   (input valid, input result_kind, input pixel_address, input run_length,
                  input pixel_data, input error_code, output ready);
endinterface

interface prld_cfg_if import prld_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [LIMIT_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/pixel_run_length_decoder.sv
// Top level of the pixel run-length decoder: decodes 32-bit code words into pixel writes, run
// fills, done, error and empty results. Depends on prld_pkg and the prld_channels interfaces.
//
//   Channel  Role    Payload                                              Transfer
//   code     sink    code_word[31:0], stream_start                        valid & ready
//   result   source  result_kind, pixel_address, run_length,              valid & ready
//                    pixel_data, error_code
//   cfg      sink    index[1:0], data[24:0] (always ready)                valid & ready
//
// Every code word gives exactly one result. A word is taken into the input register and is
// decoded from there into the result register; a new word is taken every cycle while the
// result side keeps up. The decode path is one 12x13 multiply for line-start addressing,
// adds and compares.
// Reset (rst, synchronous) empties both registers, clears the decoder state and restores
// width 640, height 480 and code limit 0. When the result side stalls, the input register
// still takes one more word and then holds it until the result register frees up.
module pixel_run_length_decoder
  import prld_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  prld_code_if.sink     code,
  prld_result_if.source result,
  prld_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [DIM_BITS-1:0]    image_width;
  logic [DIM_BITS-1:0]    image_height;
  logic [LIMIT_BITS-1:0]  code_limit;
  // Image size in pixels, recomputed every cycle from the registers above. The user must see
  // that configuration only changes while the block is idle; the block does not enforce it.
  logic [PIXELS_BITS-1:0] limit_pixels;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      code_limit   <= LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data[DIM_BITS-1:0];
        CFG_CODE_LIMIT:   code_limit   <= cfg.data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_pixels <= PIXELS_BITS'(image_width) * PIXELS_BITS'(image_height);
  end

  // Input register. It advances into the result register whenever that one is empty or
  // being drained in the same cycle.
  logic                 in_valid;
  logic [WORD_BITS-1:0] in_word;
  logic                 in_start;
  logic                 advance;

  assign advance    = in_valid && (!result.valid || result.ready);
  assign code.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (code.ready) begin
      in_valid <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code.valid && code.ready) begin
      in_word  <= code.code_word;
      in_start <= code.stream_start;
    end
  end

  // Decoder state.
  phase_t                   phase;
  logic [COUNT_BITS-1:0]    literal_remaining;
  logic [COUNT_BITS-1:0]    run_count;
  logic [POINTER_BITS-1:0]  write_pointer;
  logic [CONSUMED_BITS-1:0] words_consumed;
  logic                     stopped;

  phase_t                   phase_next;
  logic [COUNT_BITS-1:0]    literal_remaining_next;
  logic [COUNT_BITS-1:0]    run_count_next;
  logic [POINTER_BITS-1:0]  write_pointer_next;
  logic [CONSUMED_BITS-1:0] words_consumed_next;
  logic                     stopped_next;

  // Result fields computed for the word in the input register.
  logic [2:0]              kind;
  logic [POINTER_BITS-1:0] addr;
  logic [COUNT_BITS-1:0]   length;
  logic [WORD_BITS-1:0]    value;
  logic [1:0]              err;

  // Header fields and bound arithmetic.
  logic [3:0]               hdr_type;
  logic [COUNT_BITS-1:0]    hdr_count;
  logic [LINE_BITS-1:0]     hdr_line;
  logic [POINTER_BITS-1:0]  line_pointer;
  logic [POINTER_BITS-1:0]  start_pointer;
  logic [PIXELS_BITS-1:0]   dest_end;
  logic [CONSUMED_BITS:0]   src_end;
  logic                     is_line_type;

  assign hdr_type  = in_word[31:28];
  assign hdr_line  = in_word[27:16];
  assign hdr_count = in_word[15:0];
  assign line_pointer = POINTER_BITS'(hdr_line) * POINTER_BITS'(image_width);

  always_comb begin
    logic                     stop_eff;
    phase_t                   phase_eff;
    logic [POINTER_BITS-1:0]  wp_eff;
    logic [CONSUMED_BITS-1:0] wc_eff;

    // A stream start clears the state before the word is decoded.
    stop_eff  = in_start ? 1'b0      : stopped;
    phase_eff = in_start ? PH_HEADER : phase;
    wp_eff    = in_start ? '0        : write_pointer;
    wc_eff    = in_start ? '0        : words_consumed;

    phase_next             = phase_eff;
    literal_remaining_next = in_start ? '0 : literal_remaining;
    run_count_next         = in_start ? '0 : run_count;
    write_pointer_next     = wp_eff;
    words_consumed_next    = wc_eff;
    stopped_next           = stop_eff;

    kind   = KIND_NONE;
    addr   = '0;
    length = '0;
    value  = '0;
    err    = ERR_NONE;

    is_line_type  = (hdr_type != TYPE_LITERAL) && (hdr_type != TYPE_RUN);
    start_pointer = is_line_type ? line_pointer : wp_eff;
    dest_end      = PIXELS_BITS'(start_pointer) + PIXELS_BITS'(hdr_count);
    src_end       = '0;

    if (!stop_eff) begin
      // The word count saturates at its all-ones value.
      if (wc_eff != '1) begin
        words_consumed_next = wc_eff + 1'b1;
      end
      src_end = (CONSUMED_BITS + 1)'(words_consumed_next) + (CONSUMED_BITS + 1)'(hdr_count);

      unique case (phase_eff)
        PH_LITERAL: begin
          kind   = KIND_PIXEL;
          addr   = wp_eff;
          length = COUNT_BITS'(1);
          value  = in_word;
          write_pointer_next     = wp_eff + 1'b1;
          literal_remaining_next = literal_remaining - 1'b1;
          if (literal_remaining_next == '0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_RUN: begin
          phase_next = PH_HEADER;
          if (words_consumed_next > CONSUMED_BITS'(code_limit)) begin
            kind         = KIND_ERROR;
            err          = ERR_SRC_OVER;
            stopped_next = 1'b1;
          end else begin
            kind   = KIND_RUN;
            addr   = wp_eff;
            length = run_count;
            value  = in_word;
            write_pointer_next = wp_eff + POINTER_BITS'(run_count);
          end
        end
        default: begin
          // Header word. Only the very first word of a stream skips the source check.
          if (words_consumed_next > CONSUMED_BITS'(1) &&
              words_consumed_next > CONSUMED_BITS'(code_limit)) begin
            kind         = KIND_ERROR;
            err          = ERR_SRC_OVER;
            stopped_next = 1'b1;
            phase_next   = PH_HEADER;
          end else if (hdr_type == TYPE_END) begin
            kind         = KIND_DONE;
            stopped_next = 1'b1;
          end else if (hdr_type == TYPE_LITERAL || hdr_type == TYPE_LITERAL_AT_LINE) begin
            write_pointer_next = start_pointer;
            if (dest_end > limit_pixels) begin
              kind         = KIND_ERROR;
              err          = ERR_DEST_OVER;
              stopped_next = 1'b1;
              phase_next   = PH_HEADER;
            end else if (src_end > (CONSUMED_BITS + 1)'(code_limit)) begin
              kind         = KIND_ERROR;
              err          = ERR_SRC_OVER;
              stopped_next = 1'b1;
              phase_next   = PH_HEADER;
            end else begin
              literal_remaining_next = hdr_count;
              if (hdr_count != '0) begin
                phase_next = PH_LITERAL;
              end
            end
          end else if (hdr_type == TYPE_RUN || hdr_type == TYPE_RUN_AT_LINE) begin
            write_pointer_next = start_pointer;
            if (dest_end > limit_pixels) begin
              kind         = KIND_ERROR;
              err          = ERR_DEST_OVER;
              stopped_next = 1'b1;
              phase_next   = PH_HEADER;
            end else begin
              run_count_next = hdr_count;
              phase_next     = PH_RUN;
            end
          end else begin
            kind         = KIND_ERROR;
            err          = ERR_BAD_TYPE;
            stopped_next = 1'b1;
            phase_next   = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      literal_remaining <= '0;
      run_count         <= '0;
      write_pointer     <= '0;
      words_consumed    <= '0;
      stopped           <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      literal_remaining <= literal_remaining_next;
      run_count         <= run_count_next;
      write_pointer     <= write_pointer_next;
      words_consumed    <= words_consumed_next;
      stopped           <= stopped_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.result_kind   <= kind;
      result.pixel_address <= ADDR_PORT_BITS'(addr[ADDRESS_BITS-1:0]);
      result.run_length    <= length;
      result.pixel_data    <= value;
      result.error_code    <= err;
    end
  end

endmodule

// File: tb/pixel_run_length_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_run_length_decoder: a directed table and then random
// image streams under several register settings, checked against a built-in decoder model.
// Depends on prld_pkg and the channel interfaces in prld_channels.
module pixel_run_length_decoder_tb;
  import prld_pkg::*;

  // One decoded result, laid out like the result channel payload.
  typedef struct packed {
    logic [2:0]                kind;
    logic [ADDR_PORT_BITS-1:0] addr;
    logic [COUNT_BITS-1:0]     len;
    logic [WORD_BITS-1:0]      val;
    logic [1:0]                err;
  } decode_result_t;

  // A code word waiting to be sent. When fixed_want is set, the result typed into the
  // directed table is awaited instead of the model's prediction.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 start;
    logic                 fixed_want;
    decode_result_t       want;
  } code_entry_t;

  typedef struct packed {
    logic                      reg_row;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [WORD_BITS-1:0]      value;
    logic                      start;
    logic                      fixed_want;
    decode_result_t            want;
  } table_row_t;

  localparam logic ROW_CODE = 1'b0;
  localparam logic ROW_REG  = 1'b1;
  localparam logic TYPED    = 1'b1;
  localparam logic MODELED  = 1'b0;

  localparam decode_result_t IDLE_R     = '{KIND_NONE, '0, '0, '0, ERR_NONE};
  localparam decode_result_t DONE_R     = '{KIND_DONE, '0, '0, '0, ERR_NONE};
  localparam decode_result_t BADTYPE_R  = '{KIND_ERROR, '0, '0, '0, ERR_BAD_TYPE};
  localparam decode_result_t SRCOVER_R  = '{KIND_ERROR, '0, '0, '0, ERR_SRC_OVER};
  localparam decode_result_t DESTOVER_R = '{KIND_ERROR, '0, '0, '0, ERR_DEST_OVER};

  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 230;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prld_code_if   code_ch ();
  prld_result_if result_ch ();
  prld_cfg_if    cfg_ch ();

  pixel_run_length_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .code   (code_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model copy of the registers, starting from their reset values.
  logic [DIM_BITS-1:0]   width_reg  = WIDTH_RESET;
  logic [DIM_BITS-1:0]   height_reg = HEIGHT_RESET;
  logic [LIMIT_BITS-1:0] limit_reg  = LIMIT_RESET;

  // Model copy of the decoder state.
  phase_t                   ph        = PH_HEADER;
  logic [COUNT_BITS-1:0]    lit_left  = '0;
  logic [COUNT_BITS-1:0]    run_len   = '0;
  logic [POINTER_BITS-1:0]  wp        = '0;
  logic [CONSUMED_BITS-1:0] consumed  = '0;
  logic                     halted    = 1'b0;

  code_entry_t    feed[$];     // code words not yet offered to the block
  decode_result_t awaited[$];  // decoded results still owed by the block
  code_entry_t    cur_item;    // the word currently offered on the code channel

  int unsigned mismatches = 0;
  int unsigned gen_count = 0;
  int unsigned words_taken = 0;
  int unsigned reg_writes = 0;
  int unsigned n_idle = 0, n_pixel = 0, n_run = 0, n_done = 0, n_error = 0;

  int unsigned burst_left = 1, gap_left = 0;
  int unsigned ready_pct = 100, stall_left = 0, hold_left = 0, holds_done = 0;

  // Directed stimulus. The first block runs with the reset registers, where the code limit
  // of zero lets only the very first header of a stream through. Then the limit is opened
  // to its maximum for literal, empty literal, empty run and line-start checks, and finally
  // cut to three words so the source overrun hits a value word and a later header.
  table_row_t dir_rows [0:28] = '{
    '{ROW_CODE, '0, 32'h0000_0000, 1'b1, TYPED, DONE_R},
    '{ROW_CODE, '0, 32'h1234_5678, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h5000_0000, 1'b1, TYPED, BADTYPE_R},
    '{ROW_CODE, '0, 32'h1000_0001, 1'b1, TYPED, SRCOVER_R},
    '{ROW_CODE, '0, 32'h3000_0005, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'hDEAD_BEEF, 1'b0, TYPED, SRCOVER_R},
    '{ROW_CODE, '0, 32'h21E0_0001, 1'b1, TYPED, DESTOVER_R},
    '{ROW_CODE, '0, 32'h41DF_0280, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h3000_FFFF, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h0ABC_DEF0, 1'b1, TYPED, DONE_R},
    '{ROW_REG, CFG_CODE_LIMIT, 32'h01FF_FFFF, 1'b0, MODELED, IDLE_R},
    '{ROW_CODE, '0, 32'h1000_0002, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h0000_0000, 1'b0, TYPED,
      '{KIND_PIXEL, 24'd0, 16'd1, 32'h0000_0000, ERR_NONE}},
    '{ROW_CODE, '0, 32'hFFFF_FFFF, 1'b0, TYPED,
      '{KIND_PIXEL, 24'd1, 16'd1, 32'hFFFF_FFFF, ERR_NONE}},
    '{ROW_CODE, '0, 32'h1000_0000, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h3000_0000, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'hA5A5_5A5A, 1'b0, TYPED,
      '{KIND_RUN, 24'd2, 16'd0, 32'hA5A5_5A5A, ERR_NONE}},
    '{ROW_CODE, '0, 32'h4001_FFFF, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h0000_0001, 1'b0, MODELED, IDLE_R},
    '{ROW_CODE, '0, 32'h7000_0000, 1'b0, TYPED, BADTYPE_R},
    '{ROW_REG, CFG_CODE_LIMIT, 32'h0000_0003, 1'b0, MODELED, IDLE_R},
    '{ROW_CODE, '0, 32'h1000_0001, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h8765_4321, 1'b0, TYPED,
      '{KIND_PIXEL, 24'd0, 16'd1, 32'h8765_4321, ERR_NONE}},
    '{ROW_CODE, '0, 32'h3000_0001, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h1111_1111, 1'b0, TYPED, SRCOVER_R},
    '{ROW_CODE, '0, 32'h1000_0000, 1'b1, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h1000_0000, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h1000_0000, 1'b0, TYPED, IDLE_R},
    '{ROW_CODE, '0, 32'h0FFF_FFFF, 1'b0, TYPED, SRCOVER_R}
  };

  // Ends the current stream with an error: the decoder goes quiet until the next start.
  function automatic decode_result_t stop_on(logic [1:0] code);
    decode_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    halted = 1'b1;
    ph = PH_HEADER;
    return r;
  endfunction

  // Decodes one accepted code word against the model state and returns the result the
  // block owes for it.
  function automatic decode_result_t decode_word(logic [WORD_BITS-1:0] w, logic st);
    decode_result_t r;
    logic [3:0]  typ;
    logic [63:0] cnt, pixels, addr_mask;
    r = '0;
    typ = w[31:28];
    cnt = 64'(w[15:0]);
    pixels = 64'(width_reg) * 64'(height_reg);
    addr_mask = (64'd1 << ADDRESS_BITS) - 64'd1;

    // A start word clears everything before it is decoded as the first header.
    if (st) begin
      ph = PH_HEADER;
      lit_left = '0;
      run_len = '0;
      wp = '0;
      consumed = '0;
      halted = 1'b0;
    end
    if (halted) return r;
    if (consumed != '1) consumed = consumed + 1'b1;

    if (ph == PH_LITERAL) begin
      r.kind = KIND_PIXEL;
      r.addr = ADDR_PORT_BITS'(64'(wp) & addr_mask);
      r.len = 16'd1;
      r.val = w;
      wp = wp + 1'b1;
      lit_left = lit_left - 1'b1;
      if (lit_left == 0) ph = PH_HEADER;
      return r;
    end
    if (ph == PH_RUN) begin
      ph = PH_HEADER;
      if (64'(consumed) > 64'(limit_reg)) return stop_on(ERR_SRC_OVER);
      r.kind = KIND_RUN;
      r.addr = ADDR_PORT_BITS'(64'(wp) & addr_mask);
      r.len = run_len;
      r.val = w;
      wp = wp + POINTER_BITS'(run_len);
      return r;
    end

    // Header word. Only the first word of a stream escapes the source limit.
    if (consumed > 1 && 64'(consumed) > 64'(limit_reg)) return stop_on(ERR_SRC_OVER);
    if (typ == TYPE_END) begin
      halted = 1'b1;
      r.kind = KIND_DONE;
      return r;
    end
    if (typ == TYPE_LITERAL || typ == TYPE_LITERAL_AT_LINE) begin
      if (typ != TYPE_LITERAL) wp = POINTER_BITS'(64'(w[27:16]) * 64'(width_reg));
      if (64'(wp) + cnt > pixels) return stop_on(ERR_DEST_OVER);
      if (64'(consumed) + cnt > 64'(limit_reg)) return stop_on(ERR_SRC_OVER);
      lit_left = w[15:0];
      if (cnt != 0) ph = PH_LITERAL;
      return r;
    end
    if (typ == TYPE_RUN || typ == TYPE_RUN_AT_LINE) begin
      if (typ != TYPE_RUN) wp = POINTER_BITS'(64'(w[27:16]) * 64'(width_reg));
      if (64'(wp) + cnt > pixels) return stop_on(ERR_DEST_OVER);
      run_len = w[15:0];
      ph = PH_RUN;
      return r;
    end
    return stop_on(ERR_BAD_TYPE);
  endfunction

  task automatic report(string what, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
    $display("mismatch at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Random pixel or run value, with the all-zero and all-one patterns now and then.
  function automatic logic [WORD_BITS-1:0] pixel_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(logic [WORD_BITS-1:0] w, logic st);
    feed.push_back('{w, st, MODELED, IDLE_R});
    gen_count++;
  endtask

  // Queues about n random code words for the current register setting. Most of them form
  // proper streams (start, a few literal or run segments, mostly an end) with random content;
  // the rest is loose noise and streams that break off with a bad header, at times a restart.
  task automatic build_phase(int unsigned n);
    int unsigned stop_at, pick, segs, pix, line_max;
    logic [3:0]  typ;
    logic [11:0] line;
    logic [15:0] count;
    stop_at = gen_count + n;
    line_max = (height_reg == 0 || height_reg > 4096) ? 4095 : height_reg - 1;
    while (gen_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++) begin
          case ($urandom_range(0, 3))
            0: typ = TYPE_LITERAL;
            1: typ = TYPE_LITERAL_AT_LINE;
            2: typ = TYPE_RUN;
            default: typ = TYPE_RUN_AT_LINE;
          endcase
          // Line numbers mostly fall inside the image; now and then one lands past it.
          line = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, line_max));
          if (typ == TYPE_LITERAL || typ == TYPE_LITERAL_AT_LINE) begin
            count = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
            add_word({typ, line, count}, s == 0);
            // A huge literal is only partly fed; later words then decode as pixels.
            pix = (count > 4) ? 4 : count;
            for (int k = 0; k < pix; k++) add_word(pixel_word(), 1'b0);
          end else begin
            count = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16));
            add_word({typ, line, count}, s == 0);
            add_word(pixel_word(), 1'b0);
          end
        end
        if ($urandom_range(0, 5) != 0) add_word({TYPE_END, 28'($urandom)}, 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) add_word($urandom, $urandom_range(0, 3) == 0);
      end else begin
        add_word({TYPE_LITERAL, 12'($urandom), 16'($urandom_range(2, 6))}, 1'b1);
        add_word(pixel_word(), 1'b0);
        add_word({4'($urandom_range(5, 15)), 28'($urandom)}, 1'(($urandom_range(0, 1))));
      end
    end
  endtask

  // Waits until every queued word has been taken and every result has come back.
  task automatic wait_idle();
    while (feed.size() != 0 || code_ch.valid || awaited.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the decoder empty; the extra cycles cover its
  // two-stage pipeline.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [LIMIT_BITS-1:0] data);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  // Code sender: bursts of random length separated by random gaps. A new word is put up
  // only when the channel is empty or the current word transfers at this edge.
  always @(posedge clk) begin
    if (rst) begin
      code_ch.valid <= 1'b0;
      code_ch.code_word <= '0;
      code_ch.stream_start <= 1'b0;
    end else if (!code_ch.valid || code_ch.ready) begin
      if (gap_left != 0) begin
        code_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (feed.size() != 0) begin
        cur_item <= feed[0];
        code_ch.valid <= 1'b1;
        code_ch.code_word <= feed[0].word;
        code_ch.stream_start <= feed[0].start;
        void'(feed.pop_front());
        if (burst_left <= 1) begin
          // A quarter of the bursts are long and followed by no gap at all.
          if ($urandom_range(0, 3) == 0) begin
            burst_left <= $urandom_range(20, 40);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(1, 6);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        code_ch.valid <= 1'b0;
      end
    end
  end

  // Every code transfer steps the model and leaves one awaited result behind.
  always @(posedge clk) begin
    decode_result_t predicted;
    if (!rst && code_ch.valid && code_ch.ready) begin
      predicted = decode_word(code_ch.code_word, code_ch.stream_start);
      awaited.push_back(cur_item.fixed_want ? cur_item.want : predicted);
      words_taken++;
    end
  end

  // Register writes reach the model at the same edge as the block.
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_IMAGE_WIDTH:  width_reg = cfg_ch.data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_reg = cfg_ch.data[DIM_BITS-1:0];
        CFG_CODE_LIMIT:   limit_reg = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Result receiver. Short stalls come at a rate set per phase. Twice in the run it holds
  // off while words keep coming, so the block fills and has to stall its code input.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && words_taken >= 600 + 800 * holds_done) begin
      result_ch.ready <= 1'b0;
      hold_left <= 150;
      holds_done <= holds_done + 1;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) >= ready_pct) begin
      result_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Each result transfer is compared field by field with the oldest awaited result.
  always @(posedge clk) begin
    decode_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      case (result_ch.result_kind)
        KIND_NONE:  n_idle++;
        KIND_PIXEL: n_pixel++;
        KIND_RUN:   n_run++;
        KIND_DONE:  n_done++;
        default:    n_error++;
      endcase
      if (awaited.size() == 0) begin
        report("result with none awaited, kind", 32'(result_ch.result_kind), '0);
      end else begin
        want = awaited.pop_front();
        if (result_ch.result_kind !== want.kind)
          report("result_kind", 32'(result_ch.result_kind), 32'(want.kind));
        if (result_ch.pixel_address !== want.addr)
          report("pixel_address", 32'(result_ch.pixel_address), 32'(want.addr));
        if (result_ch.run_length !== want.len)
          report("run_length", 32'(result_ch.run_length), 32'(want.len));
        if (result_ch.pixel_data !== want.val)
          report("pixel_data", result_ch.pixel_data, want.val);
        if (result_ch.error_code !== want.err)
          report("error_code", 32'(result_ch.error_code), 32'(want.err));
      end
    end
  end

  initial begin
    logic [LIMIT_BITS-1:0] w_data, h_data, l_data;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].reg_row == ROW_REG) begin
        write_reg(dir_rows[k].index, dir_rows[k].value[LIMIT_BITS-1:0]);
      end else begin
        feed.push_back('{dir_rows[k].value, dir_rows[k].start, dir_rows[k].fixed_want,
                         dir_rows[k].want});
      end
    end

    // Random phases. Settings include both ends of the width and limit registers,
    // values past the nominal range (width and height of 8191, width 0) and random
    // ones with junk in the upper data bits that the registers drop.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w_data = 640;  h_data = 480;  l_data = '1; ready_pct = 100; end
        1: begin w_data = 4096; h_data = 4096; l_data = '1; ready_pct = 70; end
        2: begin w_data = 1;    h_data = 1;    l_data = '1; ready_pct = 50; end
        3: begin
          w_data = '1;
          h_data = '1;
          l_data = $urandom_range(2000, 200000);
          ready_pct = 100;
        end
        4: begin w_data = 0; h_data = 300; l_data = '1; ready_pct = 80; end
        5: begin
          w_data = $urandom_range(1, 64);
          h_data = $urandom_range(1, 64);
          l_data = $urandom_range(0, 40);
          ready_pct = 60;
        end
        6: begin w_data = 4096; h_data = 1; l_data = '0; ready_pct = 90; end
        default: begin
          w_data = {12'($urandom), 13'($urandom_range(1, 4096))};
          h_data = {12'($urandom), 13'($urandom_range(1, 4096))};
          l_data = 25'($urandom);
          ready_pct = 35;
        end
      endcase
      write_reg(CFG_IMAGE_WIDTH, w_data);
      write_reg(CFG_IMAGE_HEIGHT, h_data);
      write_reg(CFG_CODE_LIMIT, l_data);
      build_phase(PHASE_WORDS);
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("covered %0d code words under %0d register writes, with %0d long result holds",
             words_taken, reg_writes, holds_done);
    $display("results seen: %0d pixel writes, %0d run fills, %0d done, %0d errors, %0d empty",
             n_pixel, n_run, n_done, n_error, n_idle);
    if (mismatches == 0) begin
      $display("pixel_run_length_decoder verification clean");
    end else begin
      $display("pixel_run_length_decoder verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("timeout: %0d results still awaited", awaited.size());
    $display("pixel_run_length_decoder verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/prld_pkg.sv
design/prld_channels.sv
design/pixel_run_length_decoder.sv
tb/pixel_run_length_decoder_tb.sv
